// File: design/sts_pkg.sv
// Shared types, constants and codes for the sorted tuple set.
`default_nettype none
package sts_pkg;

   localparam int CAPACITY   = 64;
   localparam int DIMS       = 4;
   localparam int COORD_BITS = 16;

   localparam int TUPLE_W  = 64;
   localparam int KEY_BITS = DIMS * COORD_BITS;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [TUPLE_W-1:0] KEY_MASK =
      (KEY_BITS >= TUPLE_W) ? {TUPLE_W{1'b1}}
                            : ((TUPLE_W'(1) << KEY_BITS) - TUPLE_W'(1));

   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   typedef enum logic [1:0] {
      FUNC_LOOKUP = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_READ   = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SEARCH_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PLACE,
      ST_READ_RD,
      ST_READ_WAIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_result_type;

endpackage
`default_nettype wire

// File: design/sts_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module sts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: design/sts_cmp.sv
// Shared unsigned magnitude comparator of a stored entry against the search key.
`default_nettype none
module sts_cmp (
   input  wire logic [sts_pkg::TUPLE_W-1:0] entry,
   input  wire logic [sts_pkg::TUPLE_W-1:0] key,
   output sts_pkg::cmp_result_type          result
);

   always_comb begin
      result.lt = entry < key;
      result.eq = entry == key;
   end

endmodule
`default_nettype wire

// File: design/sts_seq.sv
// Sequencer for search, shift, place, read and clear, with result registers.
`default_nettype none
module sts_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_func,
   input  wire logic [sts_pkg::TUPLE_W-1:0]   req_index_tuple,
   input  wire logic [sts_pkg::ADDR_W-1:0]    req_position,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_found,
   output logic      [sts_pkg::ADDR_W-1:0]    rsp_slot,
   output logic      [sts_pkg::TUPLE_W-1:0]   rsp_entry_tuple,
   output logic      [sts_pkg::CNT_W-1:0]     rsp_entry_count,
   output logic      [1:0]                    rsp_status,
   output logic                               ram_wr_en,
   output logic      [sts_pkg::ADDR_W-1:0]    ram_wr_addr,
   output logic      [sts_pkg::TUPLE_W-1:0]   ram_wr_data,
   output logic                               ram_rd_en,
   output logic      [sts_pkg::ADDR_W-1:0]    ram_rd_addr,
   input  wire logic [sts_pkg::TUPLE_W-1:0]   ram_rd_data,
   output logic      [sts_pkg::TUPLE_W-1:0]   cmp_key,
   input  wire sts_pkg::cmp_result_type       cmp_result
);

   sts_pkg::state_type            state_ff, state_in;
   sts_pkg::func_type             func_ff, func_in;
   sts_pkg::status_type           status_ff, status_in;
   logic [sts_pkg::TUPLE_W-1:0]   key_ff, key_in;
   logic [sts_pkg::ADDR_W-1:0]    pos_ff, pos_in;
   logic [sts_pkg::CNT_W-1:0]     lo_ff, lo_in;
   logic [sts_pkg::CNT_W-1:0]     hi_ff, hi_in;
   logic [sts_pkg::CNT_W-1:0]     idx_ff, idx_in;
   logic [sts_pkg::CNT_W-1:0]     count_ff, count_in;
   logic                          found_ff, found_in;
   logic [sts_pkg::ADDR_W-1:0]    slot_ff, slot_in;
   logic [sts_pkg::TUPLE_W-1:0]   entry_ff, entry_in;
   logic [sts_pkg::CNT_W-1:0]     mid;
   logic [sts_pkg::CNT_W-1:0]     idx_dec;

   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_dec = idx_ff - sts_pkg::CNT_W'(1);
   assign cmp_key = key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sts_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      func_ff   <= func_in;
      status_ff <= status_in;
      key_ff    <= key_in;
      pos_ff    <= pos_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      idx_ff    <= idx_in;
      found_ff  <= found_in;
      slot_ff   <= slot_in;
      entry_ff  <= entry_in;
   end

   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      status_in   = status_ff;
      key_in      = key_ff;
      pos_in      = pos_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      found_in    = found_ff;
      slot_in     = slot_ff;
      entry_in    = entry_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff[sts_pkg::ADDR_W-1:0];
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = mid[sts_pkg::ADDR_W-1:0];

      case (state_ff)
         sts_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in   = sts_pkg::func_type'(req_func);
               key_in    = req_index_tuple & sts_pkg::KEY_MASK;
               pos_in    = req_position;
               lo_in     = '0;
               hi_in     = count_ff;
               found_in  = 1'b0;
               slot_in   = '0;
               entry_in  = '0;
               status_in = sts_pkg::STATUS_OK;
               case (sts_pkg::func_type'(req_func))
                  sts_pkg::FUNC_LOOKUP,
                  sts_pkg::FUNC_INSERT: state_in = sts_pkg::ST_SEARCH;
                  sts_pkg::FUNC_READ:   state_in = sts_pkg::ST_READ_RD;
                  default: begin
                     count_in = '0;
                     state_in = sts_pkg::ST_RESP;
                  end
               endcase
            end
         end
         sts_pkg::ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               ram_rd_en = 1'b1;
               state_in  = sts_pkg::ST_SEARCH_CMP;
            end else if (found_ff) begin
               slot_in  = lo_ff[sts_pkg::ADDR_W-1:0];
               state_in = sts_pkg::ST_RESP;
            end else if (func_ff == sts_pkg::FUNC_LOOKUP) begin
               state_in = sts_pkg::ST_RESP;
            end else if (count_ff >= sts_pkg::CAP_COUNT) begin
               status_in = sts_pkg::STATUS_FULL;
               state_in  = sts_pkg::ST_RESP;
            end else begin
               idx_in = count_ff;
               if (count_ff > lo_ff) begin
                  state_in = sts_pkg::ST_SHIFT_RD;
               end else begin
                  state_in = sts_pkg::ST_PLACE;
               end
            end
         end
         sts_pkg::ST_SEARCH_CMP: begin
            if (cmp_result.lt) begin
               lo_in = mid + sts_pkg::CNT_W'(1);
            end else begin
               hi_in = mid;
            end
            if (cmp_result.eq) begin
               found_in = 1'b1;
            end
            state_in = sts_pkg::ST_SEARCH;
         end
         sts_pkg::ST_SHIFT_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_dec[sts_pkg::ADDR_W-1:0];
            state_in    = sts_pkg::ST_SHIFT_WR;
         end
         sts_pkg::ST_SHIFT_WR: begin
            ram_wr_en = 1'b1;
            idx_in    = idx_dec;
            if (idx_dec > lo_ff) begin
               state_in = sts_pkg::ST_SHIFT_RD;
            end else begin
               state_in = sts_pkg::ST_PLACE;
            end
         end
         sts_pkg::ST_PLACE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = lo_ff[sts_pkg::ADDR_W-1:0];
            ram_wr_data = key_ff;
            count_in    = count_ff + sts_pkg::CNT_W'(1);
            slot_in     = lo_ff[sts_pkg::ADDR_W-1:0];
            state_in    = sts_pkg::ST_RESP;
         end
         sts_pkg::ST_READ_RD: begin
            if (sts_pkg::CNT_W'(pos_ff) < count_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = pos_ff;
               state_in    = sts_pkg::ST_READ_WAIT;
            end else begin
               status_in = sts_pkg::STATUS_RANGE;
               state_in  = sts_pkg::ST_RESP;
            end
         end
         sts_pkg::ST_READ_WAIT: begin
            entry_in = ram_rd_data;
            state_in = sts_pkg::ST_RESP;
         end
         sts_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = sts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sts_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_found       = found_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_entry_tuple = entry_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_status      = status_ff;

endmodule
`default_nettype wire

// File: design/sorted_tuple_set.sv
// Top level of the sorted tuple set: sequencer, entry RAM and shared comparator.
`default_nettype none
// The block holds up to 64 distinct packed tuples in ascending unsigned order in a
// single-port-read RAM and takes one item at a time; req_ready is high only while it
// is idle. A lookup is a binary search over the entries held, where each step is one
// RAM read with registered data followed by one pass through the shared comparator.
// An insert of a new tuple then moves every larger entry up one place, each by a RAM
// read and a write, and last writes the tuple. A read is a RAM read whose registered
// data is captured before the result is shown (an out-of-range read and a clear go
// straight to the response); the result then holds until rsp_ready takes it. The entry RAM
// needs no clearing after reset: entries at or above the held count are never read.
module sorted_tuple_set (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [1:0]                   req_func,
   input  wire logic [sts_pkg::TUPLE_W-1:0]  req_index_tuple,
   input  wire logic [sts_pkg::ADDR_W-1:0]   req_position,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_found,
   output logic      [sts_pkg::ADDR_W-1:0]   rsp_slot,
   output logic      [sts_pkg::TUPLE_W-1:0]  rsp_entry_tuple,
   output logic      [sts_pkg::CNT_W-1:0]    rsp_entry_count,
   output logic      [1:0]                   rsp_status
);

   logic                          ram_wr_en;
   logic [sts_pkg::ADDR_W-1:0]    ram_wr_addr;
   logic [sts_pkg::TUPLE_W-1:0]   ram_wr_data;
   logic                          ram_rd_en;
   logic [sts_pkg::ADDR_W-1:0]    ram_rd_addr;
   logic [sts_pkg::TUPLE_W-1:0]   ram_rd_data;
   logic [sts_pkg::TUPLE_W-1:0]   cmp_key;
   sts_pkg::cmp_result_type       cmp_result;

   sts_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_index_tuple (req_index_tuple),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_slot        (rsp_slot),
      .rsp_entry_tuple (rsp_entry_tuple),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .cmp_key         (cmp_key),
      .cmp_result      (cmp_result)
   );

   sts_ram #(
      .WIDTH (sts_pkg::TUPLE_W),
      .DEPTH (sts_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sts_cmp u_cmp (
      .entry  (ram_rd_data),
      .key    (cmp_key),
      .result (cmp_result)
   );

endmodule
`default_nettype wire
